FILE: hw/rtl/prp_pkg.sv
// Shared types and constants for the PageRank power-iteration block.
package prp_pkg;

   localparam int MAX_NODES = 1024;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int NCNT_W    = NODE_W + 1;
   localparam int MAX_EDGES = 8192;
   localparam int EDGE_W    = $clog2(MAX_EDGES);
   localparam int ECNT_W    = EDGE_W + 1;
   localparam int DEG_W     = ECNT_W;
   localparam int RANK_W    = 33;
   localparam int ACC_W     = RANK_W + EDGE_W + 1;
   localparam int DANG_W    = RANK_W + NODE_W + 1;
   localparam int DAMP_W    = 16;
   localparam int ITER_W    = 16;
   localparam int STAT_W    = 2;
   localparam int MODE_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};
   localparam logic [RANK_W-1:0] ONE_Q32  = {1'b1, 32'h0};

   localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RUN  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER   = 2'd3;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_RUN,
      OP_READ,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [NODE_W-1:0]   src;
      logic [NODE_W-1:0]   tgt;
   } item_type;

   typedef struct packed {
      logic [NCNT_W-1:0]    node_count;
      logic [DAMP_W-1:0]    damping;
      logic [31:0]          threshold;
      logic [ITER_W-1:0]    max_iterations;
   } cfg_type;

endpackage

FILE: hw/rtl/pagerank_power_iteration.sv
// Top level of the PageRank power-iteration block: registers, intake queue and sequencer.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_ready   mode, source_node, target_node
//   rsp      out        rsp_valid/rsp_ready   rank, iterations, status
//   csr      in         csr_valid/csr_ready   index, wdata
//
// Loads wait on the degree RAM read and reads on the rank RAM read, both registered.
// A run first sets up the initial and teleport ranks, then each pass sums the dangling
// terms, spreads a share along every stored edge (edges outside the node count are skipped)
// and updates every rank; every share and dangling term goes through the serial divider.
// After reset the out-degree store is cleared; no item is taken meanwhile.
// A two-entry queue lets intake continue while the sequencer or the result side stalls.
module pagerank_power_iteration (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [prp_pkg::MODE_W-1:0]     req_mode,
   input  logic [prp_pkg::NODE_W-1:0]     req_source_node,
   input  logic [prp_pkg::NODE_W-1:0]     req_target_node,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [prp_pkg::RANK_W-1:0]     rsp_rank,
   output logic [prp_pkg::ITER_W-1:0]     rsp_iterations,
   output logic [prp_pkg::STAT_W-1:0]     rsp_status,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [prp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [prp_pkg::CSR_DAT_W-1:0]  csr_wdata
);
   import prp_pkg::*;

   cfg_type  cfg_ff;
   logic     q_valid;
   item_type q_item;
   logic     q_pop;
   logic     clearing;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_count     <= NCNT_W'(1024);
         cfg_ff.damping        <= DAMP_W'(55706);
         cfg_ff.threshold      <= 32'd429497;
         cfg_ff.max_iterations <= ITER_W'(1000);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NODE_COUNT: cfg_ff.node_count     <= csr_wdata[NCNT_W-1:0];
            CSR_DAMPING:    cfg_ff.damping        <= csr_wdata[DAMP_W-1:0];
            CSR_THRESHOLD:  cfg_ff.threshold      <= csr_wdata;
            CSR_MAX_ITER:   cfg_ff.max_iterations <= csr_wdata[ITER_W-1:0];
            default:        cfg_ff                <= cfg_ff;
         endcase
      end
   end

   prp_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_source_node(req_source_node), .req_target_node(req_target_node),
      .clearing(clearing), .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
   );

   prp_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop), .clearing(clearing),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_rank(rsp_rank),
      .rsp_iterations(rsp_iterations), .rsp_status(rsp_status)
   );
endmodule

FILE: hw/rtl/prp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module prp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hw/rtl/prp_div.sv
// Bit-serial restoring divider: rank-sized dividend over a degree-sized divisor.
module prp_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [prp_pkg::RANK_W-1:0]  dividend,
   input  logic [prp_pkg::DEG_W-1:0]   divisor,
   output logic                        done,
   output logic [prp_pkg::RANK_W-1:0]  quotient
);
   import prp_pkg::*;

   localparam int CNT_W = $clog2(RANK_W + 1);

   logic [RANK_W-1:0] q_ff;
   logic [DEG_W-1:0]  rem_ff;
   logic [DEG_W-1:0]  dvs_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DEG_W:0]    trial;
   logic              fits;

   assign trial = {rem_ff, q_ff[RANK_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            q_ff    <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
            cnt_ff  <= CNT_W'(RANK_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (fits) begin
               rem_ff <= DEG_W'(trial - {1'b0, dvs_ff});
            end else begin
               rem_ff <= trial[DEG_W-1:0];
            end
            q_ff   <= {q_ff[RANK_W-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;
endmodule

FILE: hw/rtl/prp_front.sv
// Intake stage: accepts items, decodes the mode and queues them for the sequencer.
module prp_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [prp_pkg::MODE_W-1:0]  req_mode,
   input  logic [prp_pkg::NODE_W-1:0]  req_source_node,
   input  logic [prp_pkg::NODE_W-1:0]  req_target_node,
   input  logic                        clearing,
   output logic                        q_valid,
   output prp_pkg::item_type           q_item,
   input  logic                        q_pop
);
   import prp_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push;
   item_type   dec;

   always_comb begin
      dec.src = req_source_node;
      dec.tgt = req_target_node;
      case (req_mode)
         MODE_LOAD: dec.op = OP_LOAD;
         MODE_RUN:  dec.op = OP_RUN;
         MODE_READ: dec.op = OP_READ;
         default:   dec.op = OP_NOP;
      endcase
   end

   assign req_ready = (cnt_ff != 2'd2) && !clearing;
   assign push      = req_valid && req_ready;
   assign q_valid   = cnt_ff != 2'd0;
   assign q_item    = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, q_pop};
      end
   end
endmodule

FILE: hw/rtl/prp_back.sv
// Sequencer: edge store, degree clearing, power iterations and rank reads.
module prp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  prp_pkg::cfg_type            cfg,
   input  logic                        q_valid,
   input  prp_pkg::item_type           q_item,
   output logic                        q_pop,
   output logic                        clearing,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [prp_pkg::RANK_W-1:0]  rsp_rank,
   output logic [prp_pkg::ITER_W-1:0]  rsp_iterations,
   output logic [prp_pkg::STAT_W-1:0]  rsp_status
);
   import prp_pkg::*;

   typedef enum logic [4:0] {
      S_CLR, S_IDLE, S_DSP, S_LD_WR, S_RD_WAIT,
      S_INIT_DIV, S_TELE, S_INIT_WR, S_PASS,
      S_P1_RD, S_P1_USE, S_P1_DIV, S_P1_NEXT,
      S_P2_START, S_P2_RD, S_P2_EDGE, S_P2_CHK, S_P2_DAT, S_P2_DIV, S_P2_ACC, S_P2_NEXT,
      S_P3_RD, S_P3_SUM, S_P3_MUL, S_P3_WR, S_ITER_END
   } state_type;

   state_type            state_ff;
   item_type             item_ff;
   logic [NODE_W-1:0]    idx_ff;
   logic [EDGE_W-1:0]    e_ff;
   logic [ECNT_W-1:0]    ec_ff;
   logic [NODE_W-1:0]    es_ff;
   logic [NODE_W-1:0]    et_ff;
   logic [RANK_W-1:0]    init_ff;
   logic [RANK_W-1:0]    tele_ff;
   logic [DANG_W-1:0]    dang_ff;
   logic [RANK_W-1:0]    share_ff;
   logic [RANK_W-1:0]    sum_ff;
   logic [RANK_W-1:0]    rv_ff;
   logic [RANK_W+DAMP_W-1:0] prod_ff;
   logic [RANK_W-1:0]    lc_ff;
   logic [ITER_W-1:0]    iter_ff;
   logic                 rsp_valid_ff;
   logic [RANK_W-1:0]    rank_ff;
   logic [ITER_W-1:0]    iters_ff;
   logic [STAT_W-1:0]    status_ff;

   // Effective node count and iteration cap.
   logic [NCNT_W-1:0]    eff_n;
   logic [NODE_W-1:0]    last_idx;
   logic [ITER_W-1:0]    cap;
   logic [ITER_W:0]      iter_next;

   always_comb begin
      if (cfg.node_count == '0) begin
         eff_n = NCNT_W'(1);
      end else if (cfg.node_count > NCNT_W'(MAX_NODES)) begin
         eff_n = NCNT_W'(MAX_NODES);
      end else begin
         eff_n = cfg.node_count;
      end
   end
   assign last_idx  = NODE_W'(eff_n - 1'b1);
   assign cap       = (cfg.max_iterations == '0) ? ITER_W'(1) : cfg.max_iterations;
   assign iter_next = {1'b0, iter_ff} + 1'b1;

   // Memories.
   logic                 deg_we, edge_we, rnew_we, rold_we, acc_we;
   logic [NODE_W-1:0]    deg_wa, deg_ra, rnew_wa, rnew_ra, rold_ra, acc_wa, acc_ra;
   logic [DEG_W-1:0]     deg_wd, deg_rd;
   logic [2*NODE_W-1:0]  edge_rd;
   logic [RANK_W-1:0]    rnew_wd, rnew_rd, rold_rd;
   logic [ACC_W-1:0]     acc_wd, acc_rd;
   logic                 in_p2;

   assign in_p2 = (state_ff == S_P2_CHK) || (state_ff == S_P2_DAT) ||
                  (state_ff == S_P2_DIV) || (state_ff == S_P2_ACC);

   // Datapath for the update pass.
   logic [ACC_W:0]       sum_raw;
   logic [RANK_W-1:0]    sum_sat;
   logic [RANK_W-1:0]    dang_sat;
   logic [RANK_W:0]      nv_raw;
   logic [RANK_W-1:0]    nv;
   logic [RANK_W-1:0]    change;
   logic [RANK_W+DAMP_W:0] tele_prod;

   assign dang_sat  = (dang_ff > DANG_W'(RANK_MAX)) ? RANK_MAX : dang_ff[RANK_W-1:0];
   assign sum_raw   = {1'b0, acc_rd} + (ACC_W+1)'(dang_sat);
   assign sum_sat   = (sum_raw > (ACC_W+1)'(RANK_MAX)) ? RANK_MAX : sum_raw[RANK_W-1:0];
   assign nv_raw    = {1'b0, prod_ff[RANK_W+DAMP_W-1:DAMP_W]} + {1'b0, tele_ff};
   assign nv        = nv_raw[RANK_W] ? RANK_MAX : nv_raw[RANK_W-1:0];
   assign change    = (nv > rv_ff) ? (nv - rv_ff) : (rv_ff - nv);
   assign tele_prod = ((DAMP_W+1)'(1 << DAMP_W) - {1'b0, cfg.damping}) * init_ff;

   always_comb begin
      deg_we  = 1'b0;
      deg_wa  = item_ff.src;
      deg_wd  = deg_rd + 1'b1;
      if (state_ff == S_CLR) begin
         deg_we = 1'b1;
         deg_wa = idx_ff;
         deg_wd = '0;
      end else if (state_ff == S_LD_WR) begin
         deg_we = 1'b1;
      end
      if (in_p2) begin
         deg_ra = es_ff;
      end else if (state_ff == S_DSP || state_ff == S_LD_WR) begin
         deg_ra = item_ff.src;
      end else begin
         deg_ra = idx_ff;
      end

      edge_we = (state_ff == S_DSP) && (item_ff.op == OP_LOAD) &&
                ({1'b0, item_ff.src} < eff_n) && ({1'b0, item_ff.tgt} < eff_n) &&
                (ec_ff != ECNT_W'(MAX_EDGES));

      rnew_we = (state_ff == S_INIT_WR) || (state_ff == S_P3_WR);
      rnew_wa = idx_ff;
      rnew_wd = (state_ff == S_INIT_WR) ? init_ff : nv;
      rnew_ra = (state_ff == S_DSP || state_ff == S_RD_WAIT) ? item_ff.src : idx_ff;

      rold_we = state_ff == S_P1_USE;
      rold_ra = in_p2 ? es_ff : idx_ff;

      acc_we  = (state_ff == S_P1_USE) || (state_ff == S_P2_ACC);
      acc_wa  = (state_ff == S_P2_ACC) ? et_ff : idx_ff;
      acc_wd  = (state_ff == S_P2_ACC) ? (acc_rd + ACC_W'(share_ff)) : '0;
      acc_ra  = in_p2 ? et_ff : idx_ff;
   end

   prp_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_deg (
      .clock(clock), .wr_en(deg_we), .wr_addr(deg_wa), .wr_data(deg_wd),
      .rd_addr(deg_ra), .rd_data(deg_rd)
   );
   prp_ram #(.WIDTH(2*NODE_W), .DEPTH(MAX_EDGES)) u_edge (
      .clock(clock), .wr_en(edge_we), .wr_addr(ec_ff[EDGE_W-1:0]),
      .wr_data({item_ff.src, item_ff.tgt}), .rd_addr(e_ff), .rd_data(edge_rd)
   );
   prp_ram #(.WIDTH(RANK_W), .DEPTH(MAX_NODES)) u_rnew (
      .clock(clock), .wr_en(rnew_we), .wr_addr(rnew_wa), .wr_data(rnew_wd),
      .rd_addr(rnew_ra), .rd_data(rnew_rd)
   );
   prp_ram #(.WIDTH(RANK_W), .DEPTH(MAX_NODES)) u_rold (
      .clock(clock), .wr_en(rold_we), .wr_addr(idx_ff), .wr_data(rnew_rd),
      .rd_addr(rold_ra), .rd_data(rold_rd)
   );
   prp_ram #(.WIDTH(ACC_W), .DEPTH(MAX_NODES)) u_acc (
      .clock(clock), .wr_en(acc_we), .wr_addr(acc_wa), .wr_data(acc_wd),
      .rd_addr(acc_ra), .rd_data(acc_rd)
   );

   // Shared divider.
   logic               div_start;
   logic [RANK_W-1:0]  div_num;
   logic [DEG_W-1:0]   div_den;
   logic               div_done;
   logic [RANK_W-1:0]  div_q;

   always_comb begin
      div_start = 1'b0;
      div_num   = ONE_Q32;
      div_den   = DEG_W'(eff_n);
      case (state_ff)
         S_DSP: begin
            div_start = item_ff.op == OP_RUN;
         end
         S_P1_USE: begin
            div_start = deg_rd == '0;
            div_num   = rnew_rd;
         end
         S_P2_DAT: begin
            div_start = deg_rd != '0;
            div_num   = rold_rd;
            div_den   = deg_rd;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   prp_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .divisor(div_den), .done(div_done), .quotient(div_q)
   );

   assign q_pop = (state_ff == S_IDLE) && q_valid && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         idx_ff       <= '0;
         ec_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLR: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == NODE_W'(MAX_NODES - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (q_pop) begin
                  item_ff  <= q_item;
                  state_ff <= S_DSP;
               end
            end
            S_DSP: begin
               rank_ff   <= '0;
               iters_ff  <= '0;
               status_ff <= ST_OK;
               case (item_ff.op)
                  OP_LOAD: begin
                     if (({1'b0, item_ff.src} >= eff_n) || ({1'b0, item_ff.tgt} >= eff_n)) begin
                        status_ff    <= ST_RANGE;
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_IDLE;
                     end else if (ec_ff == ECNT_W'(MAX_EDGES)) begin
                        status_ff    <= ST_FULL;
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_IDLE;
                     end else begin
                        ec_ff    <= ec_ff + 1'b1;
                        state_ff <= S_LD_WR;
                     end
                  end
                  OP_RUN: begin
                     iter_ff  <= '0;
                     state_ff <= S_INIT_DIV;
                  end
                  OP_READ: begin
                     if ({1'b0, item_ff.src} >= eff_n) begin
                        status_ff    <= ST_RANGE;
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_IDLE;
                     end else begin
                        state_ff <= S_RD_WAIT;
                     end
                  end
                  default: begin
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end
               endcase
            end
            S_LD_WR: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            S_RD_WAIT: begin
               rank_ff      <= rnew_rd;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            S_INIT_DIV: begin
               if (div_done) begin
                  init_ff  <= div_q;
                  state_ff <= S_TELE;
               end
            end
            S_TELE: begin
               tele_ff  <= tele_prod[RANK_W+DAMP_W-1:DAMP_W];
               idx_ff   <= '0;
               state_ff <= S_INIT_WR;
            end
            S_INIT_WR: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == last_idx) begin
                  state_ff <= S_PASS;
               end
            end
            S_PASS: begin
               dang_ff  <= '0;
               idx_ff   <= '0;
               state_ff <= S_P1_RD;
            end
            S_P1_RD: begin
               state_ff <= S_P1_USE;
            end
            S_P1_USE: begin
               state_ff <= (deg_rd == '0) ? S_P1_DIV : S_P1_NEXT;
            end
            S_P1_DIV: begin
               if (div_done) begin
                  dang_ff  <= dang_ff + DANG_W'(div_q);
                  state_ff <= S_P1_NEXT;
               end
            end
            S_P1_NEXT: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == last_idx) begin
                  state_ff <= S_P2_START;
               end else begin
                  state_ff <= S_P1_RD;
               end
            end
            S_P2_START: begin
               e_ff     <= '0;
               state_ff <= (ec_ff == '0) ? S_P3_RD : S_P2_RD;
               idx_ff   <= '0;
               lc_ff    <= '0;
            end
            S_P2_RD: begin
               state_ff <= S_P2_EDGE;
            end
            S_P2_EDGE: begin
               es_ff    <= edge_rd[2*NODE_W-1:NODE_W];
               et_ff    <= edge_rd[NODE_W-1:0];
               state_ff <= S_P2_CHK;
            end
            S_P2_CHK: begin
               // Edges left over from a larger node count are skipped.
               if (({1'b0, es_ff} < eff_n) && ({1'b0, et_ff} < eff_n)) begin
                  state_ff <= S_P2_DAT;
               end else begin
                  state_ff <= S_P2_NEXT;
               end
            end
            S_P2_DAT: begin
               state_ff <= (deg_rd != '0) ? S_P2_DIV : S_P2_NEXT;
            end
            S_P2_DIV: begin
               if (div_done) begin
                  share_ff <= div_q;
                  state_ff <= S_P2_ACC;
               end
            end
            S_P2_ACC: begin
               state_ff <= S_P2_NEXT;
            end
            S_P2_NEXT: begin
               e_ff <= e_ff + 1'b1;
               if ({1'b0, e_ff} + 1'b1 == ec_ff) begin
                  idx_ff   <= '0;
                  lc_ff    <= '0;
                  state_ff <= S_P3_RD;
               end else begin
                  state_ff <= S_P2_RD;
               end
            end
            S_P3_RD: begin
               state_ff <= S_P3_SUM;
            end
            S_P3_SUM: begin
               sum_ff   <= sum_sat;
               rv_ff    <= rold_rd;
               state_ff <= S_P3_MUL;
            end
            S_P3_MUL: begin
               prod_ff  <= cfg.damping * sum_ff;
               state_ff <= S_P3_WR;
            end
            S_P3_WR: begin
               if (change > lc_ff) begin
                  lc_ff <= change;
               end
               idx_ff <= idx_ff + 1'b1;
               state_ff <= (idx_ff == last_idx) ? S_ITER_END : S_P3_RD;
            end
            S_ITER_END: begin
               iter_ff <= iter_next[ITER_W-1:0];
               if ((lc_ff <= {1'b0, cfg.threshold}) || (iter_next >= {1'b0, cap})) begin
                  iters_ff     <= iter_next[ITER_W-1:0];
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  state_ff <= S_PASS;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign clearing       = state_ff == S_CLR;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rank       = rank_ff;
   assign rsp_iterations = iters_ff;
   assign rsp_status     = status_ff;
endmodule
